### rtl/present128_block_encrypt_top_macros.svh
// Assertion macros shared by the PRESENT-128 encryption RTL.
`ifndef PRESENT128_BLOCK_ENCRYPT_TOP_MACROS_SVH
`define PRESENT128_BLOCK_ENCRYPT_TOP_MACROS_SVH

// Same-cycle implication, masked during reset
`define P128_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked during reset
`define P128_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/p128_pkg.sv
// Package for PRESENT-128 encryption: types, constants and round functions.
package p128_pkg;

   localparam int BLOCK_W = 64;
   localparam int KEY_W   = 128;
   localparam int ROUNDS  = 31;
   localparam int RND_W   = 5;
   localparam int CSR_IDX_W = 2;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type CSR_KEY_LOW  = 2'd0;
   localparam csr_idx_type CSR_KEY_HIGH = 2'd1;

   // One pipeline stage: valid bit, block state and running key
   typedef struct packed {
      logic               valid;
      logic [BLOCK_W-1:0] state;
      logic [KEY_W-1:0]   key;
   } stage_type;

   function automatic logic [3:0] sbox4(input logic [3:0] x);
      logic [3:0] y;
      case (x)
         4'h0: y = 4'hc;
         4'h1: y = 4'h5;
         4'h2: y = 4'h6;
         4'h3: y = 4'hb;
         4'h4: y = 4'h9;
         4'h5: y = 4'h0;
         4'h6: y = 4'ha;
         4'h7: y = 4'hd;
         4'h8: y = 4'h3;
         4'h9: y = 4'he;
         4'ha: y = 4'hf;
         4'hb: y = 4'h8;
         4'hc: y = 4'h4;
         4'hd: y = 4'h7;
         4'he: y = 4'h1;
         4'hf: y = 4'h2;
         default: y = 4'h0;
      endcase
      return y;
   endfunction

   function automatic logic [BLOCK_W-1:0] sub_layer(input logic [BLOCK_W-1:0] v);
      logic [BLOCK_W-1:0] res;
      for (int n = 0; n < BLOCK_W / 4; n++) begin
         res[4*n +: 4] = sbox4(v[4*n +: 4]);
      end
      return res;
   endfunction

   // Bit j moves to (16*j) mod 63; the top bit stays put
   function automatic logic [BLOCK_W-1:0] perm_layer(input logic [BLOCK_W-1:0] v);
      logic [BLOCK_W-1:0] res;
      for (int j = 0; j < BLOCK_W; j++) begin
         res[(j == BLOCK_W - 1) ? j : ((16 * j) % (BLOCK_W - 1))] = v[j];
      end
      return res;
   endfunction

   // Key schedule: rotate left 61, S-box on top byte, counter into bits 66..62
   function automatic logic [KEY_W-1:0] key_update(input logic [KEY_W-1:0] k,
                                                   input logic [RND_W-1:0] rnd);
      logic [KEY_W-1:0] r;
      r = {k[66:0], k[127:67]};
      r[127:124] = sbox4(r[127:124]);
      r[123:120] = sbox4(r[123:120]);
      r[66:62]   = r[66:62] ^ rnd;
      return r;
   endfunction

endpackage

### rtl/p128_round.sv
// One registered PRESENT round: add round key, S-box layer, permutation, key update.
module p128_round (
   input  logic                          clock,
   input  logic                          reset,
   input  p128_pkg::stage_type           stage_in,
   input  logic [p128_pkg::RND_W-1:0]    rnd,
   output p128_pkg::stage_type           stage_out
);
   import p128_pkg::*;

   stage_type stage_in_w;
   stage_type stage_ff;

   // Round datapath on the incoming word
   always_comb begin
      stage_in_w.valid = stage_in.valid;
      stage_in_w.state = perm_layer(sub_layer(stage_in.state ^ stage_in.key[KEY_W-1 -: BLOCK_W]));
      stage_in_w.key   = key_update(stage_in.key, rnd);
   end

   // Valid bit is reset; payload is not
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in_w.valid;
      end
      stage_ff.state <= stage_in_w.state;
      stage_ff.key   <= stage_in_w.key;
   end

   assign stage_out = stage_ff;

endmodule

### rtl/present128_block_encrypt_top.sv
// PRESENT-128 block encryption: 31 unrolled round stages and an output register.
// Datapath: a word accepted at a clock edge loads round stage 1, passes through
//   round stages 2 to 31 and then the final key-add output register, whose
//   registered value drives rsp_strobe and rsp_ciphertext.
// Throughput: one word per cycle; busy stays low and the receiver cannot stall.
// Reset (synchronous, active high) clears the key registers and all stage valid bits.
`include "present128_block_encrypt_top_macros.svh"

module present128_block_encrypt_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [p128_pkg::BLOCK_W-1:0]      req_plaintext,
   output logic                              rsp_strobe,
   output logic [p128_pkg::BLOCK_W-1:0]      rsp_ciphertext,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [p128_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [p128_pkg::BLOCK_W-1:0]      csr_wdata
);
   import p128_pkg::*;

   logic [BLOCK_W-1:0] key_low_ff;
   logic [BLOCK_W-1:0] key_high_ff;
   logic [BLOCK_W-1:0] key_low_in;
   logic [BLOCK_W-1:0] key_high_in;

   stage_type pipe [0:ROUNDS];

   logic               rsp_strobe_ff;
   logic [BLOCK_W-1:0] rsp_ciphertext_ff;
   logic               rsp_strobe_in;
   logic [BLOCK_W-1:0] rsp_ciphertext_in;

   // Pipeline never stalls; CSR port always ready
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // Key register writes; unknown indexes are dropped
   always_comb begin
      key_low_in  = key_low_ff;
      key_high_in = key_high_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_KEY_LOW:  key_low_in  = csr_wdata;
            CSR_KEY_HIGH: key_high_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
      end else begin
         key_low_ff  <= key_low_in;
         key_high_ff <= key_high_in;
      end
   end

   // Stage zero: incoming word with the full key
   always_comb begin
      pipe[0].valid = start && !busy;
      pipe[0].state = req_plaintext;
      pipe[0].key   = {key_high_ff, key_low_ff};
   end

   // One register stage per round
   for (genvar r = 1; r <= ROUNDS; r++) begin : g_round
      p128_round u_round (
         .clock     (clock),
         .reset     (reset),
         .stage_in  (pipe[r-1]),
         .rnd       (RND_W'(r)),
         .stage_out (pipe[r])
      );
   end

   // Final key add and output register
   assign rsp_strobe_in     = pipe[ROUNDS].valid;
   assign rsp_ciphertext_in = pipe[ROUNDS].state ^ pipe[ROUNDS].key[KEY_W-1 -: BLOCK_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rsp_ciphertext_ff <= rsp_ciphertext_in;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_ciphertext = rsp_ciphertext_ff;

   // Checks
   `P128_ASSERT_NOW(a_strobe_from_accept, clock, reset, rsp_strobe,
      $past(start && !busy, ROUNDS + 1), "result strobe without a matching accepted word")
   `P128_ASSERT_NEXT(a_key_low_write, clock, reset,
      csr_valid && csr_ready && (csr_index == CSR_KEY_LOW),
      key_low_ff == $past(csr_wdata), "key_low write lost")
   `P128_ASSERT_NEXT(a_key_high_write, clock, reset,
      csr_valid && csr_ready && (csr_index == CSR_KEY_HIGH),
      key_high_ff == $past(csr_wdata), "key_high write lost")

endmodule
